// File: hdl/hsvm_pkg.sv
// hsvm_pkg: shared types and constants for the hsv range pixel mask pipeline
// holds the pipeline payload, configuration bundle and register index codes
// no dependencies
package hsvm_pkg;

    localparam int CH_W       = 8;
    localparam int DEN_W      = 9;
    localparam int SAT_NW     = 17;
    localparam int SAT_QW     = 8;
    localparam int HUE_NW     = 14;
    localparam int HUE_QW     = 5;
    localparam int DIV_STAGES = 2;
    localparam int SAT_STEPS  = 4;
    localparam int HUE_STEPS  = 3;
    localparam int SAT_SCALE  = 510;
    localparam int HUE_SCALE  = 60;
    localparam int HUE_SPAN   = 180;
    localparam int HUE_OFS_G  = 60;
    localparam int HUE_OFS_B  = 120;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CH_W-1:0] RST_LOW  = 8'd50;
    localparam logic [CH_W-1:0] RST_HIGH = 8'd150;

    typedef enum logic [1:0] {
        HSEL_GRAY,
        HSEL_RED,
        HSEL_GREEN,
        HSEL_BLUE
    } hue_sel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_LOW     = 3'd0,
        REG_HUE_HIGH    = 3'd1,
        REG_SAT_LOW     = 3'd2,
        REG_SAT_HIGH    = 3'd3,
        REG_BRIGHT_LOW  = 3'd4,
        REG_BRIGHT_HIGH = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0] hue_low;
        logic [CH_W-1:0] hue_high;
        logic [CH_W-1:0] sat_low;
        logic [CH_W-1:0] sat_high;
        logic [CH_W-1:0] bright_low;
        logic [CH_W-1:0] bright_high;
    } hsvm_cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]   vmax;
        hue_sel_t          sel;
        logic              hneg;
        logic [SAT_NW-1:0] s_num;
        logic [DEN_W-1:0]  s_den;
        logic [SAT_QW-1:0] s_quo;
        logic [HUE_NW-1:0] h_num;
        logic [DEN_W-1:0]  h_den;
        logic [HUE_QW-1:0] h_quo;
    } hsvm_work_t;

endpackage

// File: hdl/hsvm_front.sv
// hsvm_front: first pipeline stage, max/min search and divider operand setup
// depends on hsvm_pkg
module hsvm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic [hsvm_pkg::CH_W-1:0]     blue,
    input  logic [hsvm_pkg::CH_W-1:0]     green,
    input  logic [hsvm_pkg::CH_W-1:0]     red,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output hsvm_pkg::hsvm_work_t          dn_work
);

    logic                 valid_reg;
    logic                 valid_next;
    hsvm_pkg::hsvm_work_t work_reg;
    hsvm_pkg::hsvm_work_t work_next;

    always_comb
    begin
        logic [hsvm_pkg::CH_W-1:0] vmax;
        logic [hsvm_pkg::CH_W-1:0] vmin;
        logic [hsvm_pkg::CH_W-1:0] dlt;
        logic signed [hsvm_pkg::CH_W:0] diff;
        logic [hsvm_pkg::CH_W-1:0] mag;
        hsvm_pkg::hue_sel_t sel;

        // red wins ties over green, green over blue
        if (red >= green && red >= blue)
        begin
            vmax = red;
            sel  = hsvm_pkg::HSEL_RED;
            diff = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            vmax = green;
            sel  = hsvm_pkg::HSEL_GREEN;
            diff = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            vmax = blue;
            sel  = hsvm_pkg::HSEL_BLUE;
            diff = $signed({1'b0, red}) - $signed({1'b0, green});
        end

        vmin = red;
        if (green < vmin)
        begin
            vmin = green;
        end
        if (blue < vmin)
        begin
            vmin = blue;
        end
        dlt = vmax - vmin;
        if (dlt == '0)
        begin
            sel = hsvm_pkg::HSEL_GRAY;
        end

        mag = diff[hsvm_pkg::CH_W] ? hsvm_pkg::CH_W'(-diff) : diff[hsvm_pkg::CH_W-1:0];

        work_next.vmax  = vmax;
        work_next.sel   = sel;
        work_next.hneg  = diff[hsvm_pkg::CH_W];
        // round half up: floor((510*d + v) / (2*v))
        work_next.s_num = hsvm_pkg::SAT_NW'(hsvm_pkg::SAT_SCALE * dlt)
                        + hsvm_pkg::SAT_NW'(vmax);
        work_next.s_den = {vmax, 1'b0};
        work_next.s_quo = '0;
        // magnitude form; negative side uses ceil, hence the minus one
        work_next.h_num = hsvm_pkg::HUE_NW'(hsvm_pkg::HUE_SCALE * mag)
                        + hsvm_pkg::HUE_NW'(dlt)
                        - hsvm_pkg::HUE_NW'(diff[hsvm_pkg::CH_W]);
        work_next.h_den = {dlt, 1'b0};
        work_next.h_quo = '0;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

endmodule

// File: hdl/hsvm_div_stage.sv
// hsvm_div_stage: one stage of the shift-subtract dividers for saturation and hue
// resolves a slice of quotient bits of each; depends on hsvm_pkg
module hsvm_div_stage #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  hsvm_pkg::hsvm_work_t up_work,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output hsvm_pkg::hsvm_work_t dn_work
);

    localparam int SAT_TW = hsvm_pkg::SAT_NW + hsvm_pkg::SAT_QW;
    localparam int HUE_TW = hsvm_pkg::HUE_NW + hsvm_pkg::HUE_QW;

    logic                 valid_reg;
    logic                 valid_next;
    hsvm_pkg::hsvm_work_t work_reg;
    hsvm_pkg::hsvm_work_t work_next;

    always_comb
    begin
        logic [SAT_TW-1:0] s_rem;
        logic [SAT_TW-1:0] s_try;
        logic [HUE_TW-1:0] h_rem;
        logic [HUE_TW-1:0] h_try;
        int k;

        work_next = up_work;
        s_rem     = SAT_TW'(up_work.s_num);
        h_rem     = HUE_TW'(up_work.h_num);

        // msb first; the quotient is known to fit, so no top remainder is needed
        for (int i = 0; i < hsvm_pkg::SAT_STEPS; i++)
        begin
            k = hsvm_pkg::SAT_QW - 1 - STAGE * hsvm_pkg::SAT_STEPS - i;
            if (k >= 0)
            begin
                s_try = SAT_TW'(up_work.s_den) << k;
                if (s_rem >= s_try)
                begin
                    s_rem = s_rem - s_try;
                    work_next.s_quo = work_next.s_quo | (hsvm_pkg::SAT_QW'(1) << k);
                end
            end
        end

        for (int i = 0; i < hsvm_pkg::HUE_STEPS; i++)
        begin
            k = hsvm_pkg::HUE_QW - 1 - STAGE * hsvm_pkg::HUE_STEPS - i;
            if (k >= 0)
            begin
                h_try = HUE_TW'(up_work.h_den) << k;
                if (h_rem >= h_try)
                begin
                    h_rem = h_rem - h_try;
                    work_next.h_quo = work_next.h_quo | (hsvm_pkg::HUE_QW'(1) << k);
                end
            end
        end

        work_next.s_num = s_rem[hsvm_pkg::SAT_NW-1:0];
        work_next.h_num = h_rem[hsvm_pkg::HUE_NW-1:0];
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

endmodule

// File: hdl/hsvm_back.sv
// hsvm_back: last stage, hue sector offset and wrap, range tests, output register
// depends on hsvm_pkg
module hsvm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  hsvm_pkg::hsvm_work_t      up_work,
    input  hsvm_pkg::hsvm_cfg_t       cfg,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic                      dn_in_band,
    output logic [hsvm_pkg::CH_W-1:0] dn_hue,
    output logic [hsvm_pkg::CH_W-1:0] dn_saturation,
    output logic [hsvm_pkg::CH_W-1:0] dn_brightness
);

    logic                      valid_reg;
    logic                      valid_next;
    logic                      in_band_reg;
    logic                      in_band_next;
    logic [hsvm_pkg::CH_W-1:0] hue_reg;
    logic [hsvm_pkg::CH_W-1:0] hue_next;
    logic [hsvm_pkg::CH_W-1:0] sat_reg;
    logic [hsvm_pkg::CH_W-1:0] sat_next;
    logic [hsvm_pkg::CH_W-1:0] bright_reg;
    logic [hsvm_pkg::CH_W-1:0] bright_next;

    always_comb
    begin
        logic signed [hsvm_pkg::HUE_QW+1:0] part;
        logic signed [hsvm_pkg::CH_W:0]     ext;
        logic signed [hsvm_pkg::CH_W:0]     h_s;
        logic hue_ok;
        logic sat_ok;
        logic val_ok;

        part = $signed({2'b00, up_work.h_quo});
        if (up_work.hneg)
        begin
            part = -part;
        end
        ext = {{(hsvm_pkg::CH_W - hsvm_pkg::HUE_QW - 1){part[hsvm_pkg::HUE_QW+1]}}, part};

        case (up_work.sel)
            hsvm_pkg::HSEL_RED:   h_s = ext;
            hsvm_pkg::HSEL_GREEN: h_s = ext + (hsvm_pkg::CH_W+1)'(hsvm_pkg::HUE_OFS_G);
            hsvm_pkg::HSEL_BLUE:  h_s = ext + (hsvm_pkg::CH_W+1)'(hsvm_pkg::HUE_OFS_B);
            default:              h_s = '0;
        endcase
        if (h_s < 0)
        begin
            h_s = h_s + (hsvm_pkg::CH_W+1)'(hsvm_pkg::HUE_SPAN);
        end

        hue_next    = h_s[hsvm_pkg::CH_W-1:0];
        // zero brightness gives a zero divisor; saturation is defined as zero there
        sat_next    = (up_work.vmax == '0) ? '0 : up_work.s_quo;
        bright_next = up_work.vmax;

        if (cfg.hue_low <= cfg.hue_high)
        begin
            hue_ok = (hue_next >= cfg.hue_low) && (hue_next <= cfg.hue_high);
        end
        else
        begin
            hue_ok = (hue_next <= cfg.hue_high) || (hue_next >= cfg.hue_low);
        end
        sat_ok = (sat_next >= cfg.sat_low) && (sat_next <= cfg.sat_high);
        val_ok = (bright_next >= cfg.bright_low) && (bright_next <= cfg.bright_high);
        in_band_next = hue_ok && sat_ok && val_ok;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            in_band_reg <= in_band_next;
            hue_reg     <= hue_next;
            sat_reg     <= sat_next;
            bright_reg  <= bright_next;
        end
    end

    assign dn_valid      = valid_reg;
    assign dn_in_band    = in_band_reg;
    assign dn_hue        = hue_reg;
    assign dn_saturation = sat_reg;
    assign dn_brightness = bright_reg;

endmodule

// File: hdl/hsv_range_pixel_mask.sv
// hsv_range_pixel_mask: top level, bgr pixel to 8-bit hsv with inclusive range test
// depends on hsvm_pkg, hsvm_front, hsvm_div_stage, hsvm_back
//
// One pixel beat in, one result beat out. The pipeline is four register stages deep:
// channel max/min and operand setup, two shift-subtract divider stages that resolve
// saturation and hue quotient bits side by side, then hue sector offset, range tests
// and the output register. It takes a beat every cycle while the output side does
// not stall. Each stage holds its beat under backpressure and fills bubbles ahead of
// a stall. Range bounds are plain registers written through
// cfg_we/cfg_index/cfg_data; indexes beyond the sixth register are ignored. Change
// them only while no beat is in flight.
module hsv_range_pixel_mask (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hsvm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hsvm_pkg::CH_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [hsvm_pkg::CH_W-1:0]          blue,
    input  logic [hsvm_pkg::CH_W-1:0]          green,
    input  logic [hsvm_pkg::CH_W-1:0]          red,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               in_band,
    output logic [hsvm_pkg::CH_W-1:0]          hue,
    output logic [hsvm_pkg::CH_W-1:0]          saturation,
    output logic [hsvm_pkg::CH_W-1:0]          brightness
);

    hsvm_pkg::hsvm_cfg_t  cfg_reg;
    hsvm_pkg::hsvm_cfg_t  cfg_next;

    logic                 stg_valid [hsvm_pkg::DIV_STAGES+1];
    logic                 stg_ready [hsvm_pkg::DIV_STAGES+1];
    hsvm_pkg::hsvm_work_t stg_work  [hsvm_pkg::DIV_STAGES+1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (hsvm_pkg::cfg_reg_t'(cfg_index))
                hsvm_pkg::REG_HUE_LOW:     cfg_next.hue_low     = cfg_data;
                hsvm_pkg::REG_HUE_HIGH:    cfg_next.hue_high    = cfg_data;
                hsvm_pkg::REG_SAT_LOW:     cfg_next.sat_low     = cfg_data;
                hsvm_pkg::REG_SAT_HIGH:    cfg_next.sat_high    = cfg_data;
                hsvm_pkg::REG_BRIGHT_LOW:  cfg_next.bright_low  = cfg_data;
                hsvm_pkg::REG_BRIGHT_HIGH: cfg_next.bright_high = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_low     <= hsvm_pkg::RST_LOW;
            cfg_reg.hue_high    <= hsvm_pkg::RST_HIGH;
            cfg_reg.sat_low     <= hsvm_pkg::RST_LOW;
            cfg_reg.sat_high    <= hsvm_pkg::RST_HIGH;
            cfg_reg.bright_low  <= hsvm_pkg::RST_LOW;
            cfg_reg.bright_high <= hsvm_pkg::RST_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hsvm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .blue     (blue),
        .green    (green),
        .red      (red),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .dn_work  (stg_work[0])
    );

    for (genvar s = 0; s < hsvm_pkg::DIV_STAGES; s++)
    begin : g_div
        hsvm_div_stage #(
            .STAGE (s)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[s]),
            .up_ready (stg_ready[s]),
            .up_work  (stg_work[s]),
            .dn_valid (stg_valid[s+1]),
            .dn_ready (stg_ready[s+1]),
            .dn_work  (stg_work[s+1])
        );
    end

    hsvm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (stg_valid[hsvm_pkg::DIV_STAGES]),
        .up_ready      (stg_ready[hsvm_pkg::DIV_STAGES]),
        .up_work       (stg_work[hsvm_pkg::DIV_STAGES]),
        .cfg           (cfg_reg),
        .dn_valid      (out_valid),
        .dn_ready      (out_ready),
        .dn_in_band    (in_band),
        .dn_hue        (hue),
        .dn_saturation (saturation),
        .dn_brightness (brightness)
    );

    // hue stays inside its 0..179 span
    a_hue_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue < hsvm_pkg::CH_W'(hsvm_pkg::HUE_SPAN)))
        else $error("hue out of span");

    // black pixel has no saturation
    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && brightness == '0) |-> (saturation == '0))
        else $error("nonzero saturation at zero brightness");

    // zero saturation only for gray pixels, whose hue is zero
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturation == '0) |-> (hue == '0))
        else $error("gray pixel with nonzero hue");

    // an empty output register means every stage can take a beat
    a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with empty output");

endmodule
